/* rtl/core/bdeq_pkg.sv */
// ----------------------------------------------------------------------------
// bdeq_pkg
// Operation and status codes, field widths and parameter defaults of the
// bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdeq_pkg;

  localparam int DEFAULT_DEPTH      = 32;
  localparam int DEFAULT_VALUE_BITS = 8;

  localparam int FUNC_W   = 3;
  localparam int DATA_W   = 8;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 6;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  typedef logic [FUNC_W-1:0]   func_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam func_t FUNC_PUSH_FRONT = 3'd0;
  localparam func_t FUNC_PUSH_BACK  = 3'd1;
  localparam func_t FUNC_POP_FRONT  = 3'd2;
  localparam func_t FUNC_POP_BACK   = 3'd3;
  localparam func_t FUNC_DUMP       = 3'd4;
  localparam func_t FUNC_PEEK_FRONT = 3'd5;
  localparam func_t FUNC_PEEK_BACK  = 3'd6;

  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_EMPTY = 2'd1;
  localparam status_t STAT_FULL  = 2'd2;

endpackage

/* rtl/core/bounded_double_ended_queue.sv */
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Push, pop, empty and rejected operations: result registered in the cycle after
// accept, one item per cycle unless output stalls. Peek: read register, then result
// register. Dump of N entries: one entry per cycle out of the ring memory unless stalled.
// Reset clears front index, count and pending results; ring contents are kept.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue #(
  parameter int DEPTH      = bdeq_pkg::DEFAULT_DEPTH,
  parameter int VALUE_BITS = bdeq_pkg::DEFAULT_VALUE_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [bdeq_pkg::IN_TDATA_W-1:0]    in_tdata,   // [7:0] data_value
  input  logic [bdeq_pkg::FUNC_W-1:0]        in_tuser,   // [2:0] func
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [bdeq_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [7:0] read_value, [13:8] occupancy
  output logic [bdeq_pkg::STATUS_W-1:0]      out_tuser,  // [1:0] status
  output logic                               out_tlast   // last
);

  import bdeq_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RD   = 1'b1;

  logic [VALUE_BITS-1:0] mem_r [DEPTH];
  logic [VALUE_BITS-1:0] rd_data_r;

  logic                  state_r,  state_nxt;
  logic [IW-1:0]         front_r,  front_nxt;
  logic [CW-1:0]         count_r,  count_nxt;
  logic [CW-1:0]         rem_r,    rem_nxt;
  logic [IW-1:0]         pos_r,    pos_nxt;

  logic                  out_valid_r;
  logic [DATA_W-1:0]     out_value_r, out_value_nxt;
  logic [OCC_W-1:0]      out_occ_r,   out_occ_nxt;
  status_t               out_stat_r,  out_stat_nxt;
  logic                  out_last_r,  out_last_nxt;
  logic                  out_load;

  logic                  slot_free;
  logic                  in_fire;
  func_t                 func;
  logic                  empty;
  logic                  full;
  logic [IW-1:0]         front_dec;
  logic [IW-1:0]         front_inc;
  logic [IW+1:0]         tail_sum;
  logic [IW-1:0]         tail_pos;
  logic [IW-1:0]         back_pos;
  logic [IW-1:0]         pos_dec;

  logic                  we;
  logic [IW-1:0]         waddr;
  logic [VALUE_BITS+DATA_W-1:0] wdata_ext;
  logic                  rd_en;
  logic [IW-1:0]         raddr;
  logic [CW+OCC_W-1:0]   occ_ext;
  logic [VALUE_BITS+DATA_W-1:0] rd_ext;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && slot_free;
  assign in_fire   = in_tvalid && in_tready;
  assign func      = in_tuser;
  assign empty     = (count_r == '0);
  assign full      = (count_r == CW'(DEPTH));

  assign front_dec = (front_r == '0) ? IW'(DEPTH - 1) : front_r - 1'b1;
  assign front_inc = (front_r == IW'(DEPTH - 1)) ? '0 : front_r + 1'b1;
  assign tail_sum  = (IW+2)'(front_r) + (IW+2)'(count_r);
  assign tail_pos  = (tail_sum >= (IW+2)'(DEPTH)) ?
                     IW'(tail_sum - (IW+2)'(DEPTH)) : IW'(tail_sum);
  assign back_pos  = (tail_pos == '0) ? IW'(DEPTH - 1) : tail_pos - 1'b1;
  assign pos_dec   = (pos_r == '0) ? IW'(DEPTH - 1) : pos_r - 1'b1;

  assign wdata_ext = {{VALUE_BITS{1'b0}}, in_tdata[DATA_W-1:0]};
  assign rd_ext    = {{DATA_W{1'b0}}, rd_data_r};

  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    pos_nxt       = pos_r;
    out_load      = 1'b0;
    out_value_nxt = '0;
    out_stat_nxt  = STAT_OK;
    out_last_nxt  = 1'b1;
    we            = 1'b0;
    waddr         = tail_pos;
    rd_en         = 1'b0;
    raddr         = back_pos;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (func) inside
            FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
              out_load = 1'b1;
              if (full) begin
                out_stat_nxt = STAT_FULL;
              end else begin
                we        = 1'b1;
                count_nxt = count_r + 1'b1;
                if (func == FUNC_PUSH_FRONT) begin
                  waddr     = front_dec;
                  front_nxt = front_dec;
                end
              end
            end
            FUNC_POP_FRONT, FUNC_POP_BACK: begin
              out_load = 1'b1;
              if (empty) begin
                out_stat_nxt = STAT_EMPTY;
              end else begin
                count_nxt = count_r - 1'b1;
                if (func == FUNC_POP_FRONT) begin
                  front_nxt = front_inc;
                end
              end
            end
            FUNC_DUMP, FUNC_PEEK_FRONT, FUNC_PEEK_BACK: begin
              if (empty) begin
                out_load     = 1'b1;
                out_stat_nxt = STAT_EMPTY;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_RD;
                rem_nxt   = (func == FUNC_DUMP) ? count_r : CW'(1);
                raddr     = (func == FUNC_PEEK_FRONT) ? front_r : back_pos;
                pos_nxt   = raddr;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        if (slot_free) begin
          out_load      = 1'b1;
          out_value_nxt = rd_ext[DATA_W-1:0];
          out_last_nxt  = (rem_r == CW'(1));
          if (rem_r == CW'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            raddr   = pos_dec;
            pos_nxt = pos_dec;
            rem_nxt = rem_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign occ_ext     = {{OCC_W{1'b0}}, count_nxt};
  assign out_occ_nxt = occ_ext[OCC_W-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata_ext[VALUE_BITS-1:0];
    end
    if (rd_en) begin
      rd_data_r <= mem_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      rem_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
      rem_r   <= rem_nxt;
      pos_r   <= pos_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= out_value_nxt;
      out_occ_r   <= out_occ_nxt;
      out_stat_r  <= out_stat_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_occ_r, out_value_r};
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_rd_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> (rem_r != '0))
    else $error("read state with nothing left to send");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && full && (func == FUNC_PUSH_FRONT || func == FUNC_PUSH_BACK))
      |=> $stable(count_r) && $stable(front_r))
    else $error("rejected push changed the queue");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !empty && (func == FUNC_POP_FRONT || func == FUNC_POP_BACK))
      |=> (count_r == CW'($past(count_r) - 1'b1)))
    else $error("pop did not shrink the queue by one");

endmodule

/* bench/bounded_double_ended_queue_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_test
// Drives operation beats into the double-ended queue and checks every result
// beat against a behavioral ring model kept inside the bench. Directed tests
// cover the empty queue, both ends and the unused selector. A back-pressure
// test holds off the result side and pushes the queue past its bound. Random
// rounds alternate between fill-heavy and drain-heavy mixes. Both sides idle
// at random.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_test;
  import bdeq_pkg::*;

  localparam int     DEPTH       = DEFAULT_DEPTH;
  localparam func_t  FUNC_UNUSED = 3'd7;
  localparam int     HOLD_CYCLES = 300;
  localparam int     DRAIN_LIMIT = 20000;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    status_t           status;
    logic              last;
    logic [OCC_W-1:0]  occupancy;
  } deque_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [7:0] data_value
  logic [FUNC_W-1:0]      in_tuser;   // [2:0] func
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [7:0] read_value, [13:8] occupancy
  logic [STATUS_W-1:0]    out_tuser;  // [1:0] status
  logic                   out_tlast;  // last

  logic [DATA_W-1:0] ring_model [DEPTH];
  int                front_model;
  int                count_model;
  deque_result_t     pending_results [$];
  deque_result_t     want;

  int  error_count;
  int  mismatch_count;
  int  beats_sent;
  int  results_checked;
  int  full_rejects;
  int  empty_hits;
  int  dumps_seen;
  bit  tx_steady;
  bit  rx_steady;
  int  hold_tag;
  int  hold_seen;
  int  hold_left;

  bounded_double_ended_queue u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: random stalls, steady stretches and one counted hold-off.
  initial begin
    out_tready = 1'b0;
    hold_seen  = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_tag != hold_seen) begin
        hold_seen = hold_tag;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (rx_steady) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 37);
      end
    end
  end

  task automatic push_result(logic [DATA_W-1:0] value, status_t status, logic last);
    deque_result_t r;
    r.read_value = value;
    r.status     = status;
    r.last       = last;
    r.occupancy  = count_model[OCC_W-1:0];
    pending_results.push_back(r);
  endtask

  function automatic int ring_at(int offset);
    return (front_model + offset) % DEPTH;
  endfunction

  task automatic predict_deque_op(func_t func, logic [DATA_W-1:0] value);
    bit empty;
    bit full;
    empty = (count_model == 0);
    full  = (count_model >= DEPTH);
    if (func == FUNC_UNUSED) return;
    if ((func == FUNC_PUSH_FRONT || func == FUNC_PUSH_BACK) && full) begin
      full_rejects++;
      push_result('0, STAT_FULL, 1'b1);
      return;
    end
    if (func != FUNC_PUSH_FRONT && func != FUNC_PUSH_BACK && empty) begin
      empty_hits++;
      push_result('0, STAT_EMPTY, 1'b1);
      return;
    end
    case (func)
      FUNC_PUSH_FRONT: begin
        front_model = ring_at(DEPTH - 1);
        ring_model[front_model] = value;
        count_model++;
        push_result('0, STAT_OK, 1'b1);
      end
      FUNC_PUSH_BACK: begin
        ring_model[ring_at(count_model)] = value;
        count_model++;
        push_result('0, STAT_OK, 1'b1);
      end
      FUNC_POP_FRONT: begin
        front_model = ring_at(1);
        count_model--;
        push_result('0, STAT_OK, 1'b1);
      end
      FUNC_POP_BACK: begin
        count_model--;
        push_result('0, STAT_OK, 1'b1);
      end
      FUNC_DUMP: begin
        dumps_seen++;
        for (int k = 0; k < count_model; k++)
          push_result(ring_model[ring_at(count_model - 1 - k)], STAT_OK,
                      (k + 1 == count_model));
      end
      FUNC_PEEK_FRONT: push_result(ring_model[ring_at(0)], STAT_OK, 1'b1);
      FUNC_PEEK_BACK:  push_result(ring_model[ring_at(count_model - 1)], STAT_OK, 1'b1);
      default: ;
    endcase
  endtask

  task automatic send_beat(func_t func, logic [DATA_W-1:0] value);
    while (!tx_steady && $urandom_range(99) < 37) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
    predict_deque_op(func, value);
  endtask

  task automatic report_field(string name, int expected, int actual);
    error_count++;
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s at %0t: expected %0d, got %0d", name, $realtime,
               expected, actual);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat at %0t: tdata %h status %0d last %0d",
                   $realtime, out_tdata, out_tuser, out_tlast);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_tdata[7:0] !== want.read_value)
          report_field("read_value", int'(want.read_value), int'(out_tdata[7:0]));
        if (out_tdata[13:8] !== want.occupancy)
          report_field("occupancy", int'(want.occupancy), int'(out_tdata[13:8]));
        if (out_tdata[15:14] !== 2'b00)
          report_field("tdata padding", 0, int'(out_tdata[15:14]));
        if (out_tuser !== want.status)
          report_field("status", int'(want.status), int'(out_tuser));
        if (out_tlast !== want.last)
          report_field("last", int'(want.last), int'(out_tlast));
      end
    end
  end

  task automatic test_empty_queue();
    send_beat(FUNC_POP_FRONT, 8'h00);
    send_beat(FUNC_POP_BACK, 8'hFF);
    send_beat(FUNC_PEEK_FRONT, 8'h5A);
    send_beat(FUNC_PEEK_BACK, 8'hA5);
    send_beat(FUNC_DUMP, 8'h00);
    send_beat(FUNC_UNUSED, 8'hFF);
  endtask

  task automatic test_both_ends();
    send_beat(FUNC_PUSH_FRONT, 8'h00);
    send_beat(FUNC_PUSH_BACK, 8'hFF);
    send_beat(FUNC_PUSH_FRONT, 8'hA5);
    send_beat(FUNC_UNUSED, 8'h5A);
    send_beat(FUNC_PEEK_FRONT, 8'h00);
    send_beat(FUNC_PEEK_BACK, 8'h00);
    send_beat(FUNC_DUMP, 8'hFF);
    send_beat(FUNC_POP_FRONT, 8'h00);
    send_beat(FUNC_PEEK_FRONT, 8'h00);
    send_beat(FUNC_POP_BACK, 8'h00);
    send_beat(FUNC_PEEK_BACK, 8'h00);
    send_beat(FUNC_POP_FRONT, 8'h00);
    send_beat(FUNC_DUMP, 8'h00);
  endtask

  // Hold off the result side while pushes run the queue past its bound.
  task automatic test_backpressure_full();
    tx_steady = 1'b1;
    hold_tag++;
    for (int i = 0; i < DEPTH + 6; i++)
      send_beat($urandom_range(1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK, 8'($urandom));
    send_beat(FUNC_PEEK_FRONT, 8'h00);
    send_beat(FUNC_PEEK_BACK, 8'h00);
    send_beat(FUNC_DUMP, 8'h00);
    tx_steady = 1'b0;
    while (count_model > 0)
      send_beat($urandom_range(1) ? FUNC_POP_FRONT : FUNC_POP_BACK, 8'($urandom));
  endtask

  function automatic func_t pick_func(bit fill);
    int roll;
    roll = $urandom_range(99);
    if (roll < 3)  return FUNC_UNUSED;
    if (roll < 9)  return FUNC_DUMP;
    if (roll < 19) return FUNC_PEEK_FRONT;
    if (roll < 29) return FUNC_PEEK_BACK;
    if (roll < (fill ? 45 : 70))
      return $urandom_range(1) ? FUNC_POP_FRONT : FUNC_POP_BACK;
    return $urandom_range(1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
  endfunction

  task automatic test_random_mix();
    for (int round = 0; round < 6; round++) begin
      tx_steady = (round == 3);
      rx_steady = (round == 3);
      for (int i = 0; i < 65; i++)
        send_beat(pick_func(round % 2 == 0), 8'($urandom_range(255)));
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    tx_steady   = 1'b0;
    rx_steady   = 1'b0;
    hold_tag    = 0;
    front_model = 0;
    count_model = 0;
    error_count = 0;
    mismatch_count  = 0;
    beats_sent      = 0;
    results_checked = 0;
    full_rejects    = 0;
    empty_hits      = 0;
    dumps_seen      = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_queue();
    test_both_ends();
    test_backpressure_full();
    test_random_mix();

    @(negedge clk);
    in_tvalid <= 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && pending_results.size() > 0; i++)
      @(posedge clk);
    if (pending_results.size() > 0) begin
      error_count++;
      $display("%0d expected result beats never arrived", pending_results.size());
    end
    repeat (2 * DEPTH + 10) @(posedge clk);

    $display("Sent %0d operation beats and checked %0d result beats,", beats_sent,
             results_checked);
    $display("including %0d dumps, %0d full rejects and %0d empty-queue results.",
             dumps_seen, full_rejects, empty_hits);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
